/* design/sar_pkg.sv */
package sar_pkg;

  // Widened coordinate used for the swept box and table edges.
  localparam int C_W = 34;
  // Widened signed distance.
  localparam int D_W = 35;

  typedef logic signed [C_W-1:0] coord_t;
  typedef logic signed [D_W-1:0] dist_t;

  // Item command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MOVE  = 1'b1;

  // Axis codes.
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Saturation bounds of the 32-bit result, in widened form.
  localparam coord_t SAT_MAX = {{(C_W-31){1'b0}}, {31{1'b1}}};
  localparam coord_t SAT_MIN = {{(C_W-31){1'b1}}, {31{1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // One table entry as held in the box memory.
  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic [30:0]        width;
    logic [30:0]        height;
    logic               collidable;
  } entry_t;

  // Swept box of the move under way, handed to the test unit.
  typedef struct packed {
    coord_t             x_lo;
    coord_t             x_hi;
    coord_t             y_lo;
    coord_t             y_hi;
    logic signed [31:0] cur;
    logic               axis;
  } sweep_t;

  // Nearest blocking box found so far.
  typedef struct packed {
    logic               found;
    logic signed [31:0] near;
    logic [30:0]        ext;
  } best_t;

  function automatic coord_t sext_c(input logic signed [31:0] v);
    sext_c = {{(C_W-32){v[31]}}, v};
  endfunction

  function automatic coord_t zext_c(input logic [30:0] v);
    zext_c = {{(C_W-31){1'b0}}, v};
  endfunction

  function automatic dist_t sext_d(input logic signed [31:0] v);
    sext_d = {{(D_W-32){v[31]}}, v};
  endfunction

  function automatic dist_t zext_d(input logic [30:0] v);
    zext_d = {{(D_W-31){1'b0}}, v};
  endfunction

  function automatic dist_t abs_d(input dist_t v);
    abs_d = v[D_W-1] ? -v : v;
  endfunction

endpackage

/* design/sar_ram.sv */
module sar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/sar_test_unit.sv */
module sar_test_unit import sar_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             in_valid,
  input  logic [IDX_W-1:0] in_idx,
  input  entry_t           entry,
  input  sweep_t           sweep,
  input  logic [IDX_W-1:0] mover,
  output logic             pipe_busy,
  output best_t            best,
  output logic [IDX_W-1:0] best_idx
);

  // Stage 1 registers: overlap passed, edge distance to the near side.
  logic               v1;
  logic [IDX_W-1:0]   idx1;
  logic signed [31:0] near1;
  logic [30:0]        ext1;
  dist_t              diff1;

  // Stage 2 registers.
  logic               v2;
  logic [IDX_W-1:0]   idx2;
  logic signed [31:0] near2;
  logic [30:0]        ext2;
  dist_t              diff2;
  dist_t              ad1;

  // Stage 3 registers.
  logic               v3;
  logic [IDX_W-1:0]   idx3;
  logic signed [31:0] near3;
  logic [30:0]        ext3;
  dist_t              d3;

  dist_t              best_d;

  coord_t             ex_lo;
  coord_t             ex_hi;
  coord_t             ey_lo;
  coord_t             ey_hi;
  logic               overlap;
  logic               take;
  logic signed [31:0] near_sel;
  logic [30:0]        ext_sel;
  dist_t              ad2;

  // Strict overlap of the table box against the swept box.
  always_comb begin
    ex_lo    = sext_c(entry.left);
    ex_hi    = ex_lo + zext_c(entry.width);
    ey_lo    = sext_c(entry.top);
    ey_hi    = ey_lo + zext_c(entry.height);
    overlap  = (sweep.x_lo < ex_hi) && (sweep.x_hi > ex_lo) &&
               (sweep.y_lo < ey_hi) && (sweep.y_hi > ey_lo);
    take     = in_valid && entry.collidable && (in_idx != mover) && overlap;
    near_sel = (sweep.axis == AXIS_Y) ? entry.top : entry.left;
    ext_sel  = (sweep.axis == AXIS_Y) ? entry.height : entry.width;
    ad2      = abs_d(diff2);
  end

  assign pipe_busy = v1 | v2 | v3;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Distance pipeline: near edge, far edge, then the smaller of the two.
  always_ff @(posedge clk) begin
    idx1  <= in_idx;
    near1 <= near_sel;
    ext1  <= ext_sel;
    diff1 <= sext_d(near_sel) - sext_d(sweep.cur);

    idx2  <= idx1;
    near2 <= near1;
    ext2  <= ext1;
    diff2 <= diff1 + zext_d(ext1);
    ad1   <= abs_d(diff1);

    idx3  <= idx2;
    near3 <= near2;
    ext3  <= ext2;
    d3    <= (ad1 < ad2) ? ad1 : ad2;
  end

  // Keep the nearest hit; entries arrive in rising index order, so a tie
  // keeps the earlier one.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.found <= 1'b0;
    end else if (v3 && (!best.found || d3 < best_d)) begin
      best.found <= 1'b1;
    end
    if (v3 && (!best.found || d3 < best_d)) begin
      best_d    <= d3;
      best_idx  <= idx3;
      best.near <= near3;
      best.ext  <= ext3;
    end
  end

endmodule

/* design/swept_aabb_axis_resolver.sv */
// Swept box resolver. A table of MAX_ENTRIES axis-aligned boxes in Q15.16
// is written one entry per item (cmd = 0, no result). A move item (cmd = 1)
// sweeps the named box along one axis toward dest_pos and returns, on done
// for one cycle, the coordinate it may reach, with the nearest blocking
// entry. The receiver cannot stall; a result is shown for exactly one cycle.
// The single-port box table is read one entry per cycle by a pipelined
// overlap and distance unit, the drain waits for the last read and for any
// hits still in that unit, and busy stays high throughout. A move whose
// position already equals dest_pos finishes without a scan, and a move
// naming an index beyond the table gives no result. After reset the block
// runs a clearing pass, busy high, that zeroes every entry and so clears
// every collidable flag.
module swept_aabb_axis_resolver import sar_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [5:0]         entry_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [30:0]        width,
  input  logic [30:0]        height,
  input  logic               collidable,
  input  logic               axis,
  input  logic signed [31:0] dest_pos,
  output logic               done,
  output logic signed [31:0] result_pos,
  output logic               hit,
  output logic [5:0]         hit_index
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  state_t             state;
  state_t             state_next;

  logic [IDX_W-1:0]   ptr;
  logic               rd_valid;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   mover;
  logic               move_axis;
  logic signed [31:0] dest;
  logic [30:0]        size;
  sweep_t             sweep;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;

  logic               accept;
  logic               in_range;
  logic               pipe_busy;
  best_t              best;
  logic [IDX_W-1:0]   best_idx;

  logic signed [31:0] m_cur;
  logic [30:0]        m_size;
  logic signed [31:0] m_oth;
  logic [30:0]        m_osize;
  coord_t             cur_c;
  coord_t             dest_c;
  coord_t             a_lo;
  coord_t             a_hi;
  coord_t             b_lo;
  coord_t             b_hi;
  coord_t             near_c;
  coord_t             res_c;
  logic signed [31:0] res_sat;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(entry_index) < 32'(MAX_ENTRIES));

  // Box table.
  sar_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Shared overlap and distance unit.
  sar_test_unit #(
    .IDX_W (IDX_W)
  ) u_test (
    .clk       (clk),
    .rst       (rst),
    .clear     (state == ST_SETUP),
    .in_valid  (rd_valid),
    .in_idx    (rd_idx),
    .entry     (ram_rdata),
    .sweep     (sweep),
    .mover     (mover),
    .pipe_busy (pipe_busy),
    .best      (best),
    .best_idx  (best_idx)
  );

  // Table port: clearing pass, item writes, mover read, then the scan.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = IDX_W'(entry_index);
    ram_wdata = '{left: pos_x, top: pos_y, width: width, height: height,
                  collidable: collidable};
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = ptr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_we = accept && (cmd == CMD_WRITE) && in_range;
      end
      ST_SCAN: begin
        ram_addr = ptr;
      end
      default: begin
        ram_addr = ptr;
      end
    endcase
  end

  // Swept box of the mover, from the entry read at accept.
  always_comb begin
    m_cur   = (move_axis == AXIS_Y) ? ram_rdata.top : ram_rdata.left;
    m_size  = (move_axis == AXIS_Y) ? ram_rdata.height : ram_rdata.width;
    m_oth   = (move_axis == AXIS_Y) ? ram_rdata.left : ram_rdata.top;
    m_osize = (move_axis == AXIS_Y) ? ram_rdata.width : ram_rdata.height;
    cur_c   = sext_c(m_cur);
    dest_c  = sext_c(dest);
    if (dest > m_cur) begin
      a_lo = cur_c + zext_c(m_size);
      a_hi = dest_c + zext_c(m_size);
    end else begin
      a_lo = dest_c;
      a_hi = cur_c;
    end
    b_lo = sext_c(m_oth);
    b_hi = b_lo + zext_c(m_osize);
  end

  // Final position against the winning box, saturated to 32 bits.
  always_comb begin
    near_c = sext_c(best.near);
    if (!best.found) begin
      res_c = sext_c(dest);
    end else if (sext_c(sweep.cur) < near_c) begin
      res_c = near_c - zext_c(size);
    end else begin
      res_c = near_c + zext_c(best.ext);
    end
    if (res_c > SAT_MAX) begin
      res_sat = 32'sh7FFF_FFFF;
    end else if (res_c < SAT_MIN) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = res_c[31:0];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (ptr == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (cmd == CMD_MOVE) && in_range) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = (dest == m_cur) ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (ptr == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Entry pointer, read pipeline valid and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
      done     <= ((state == ST_SETUP) && (dest == m_cur)) || (state == ST_FINISH);
      if ((state == ST_CLEAR) || (state == ST_SCAN)) begin
        ptr <= (ptr == LAST_IDX) ? '0 : ptr + IDX_W'(1);
      end else begin
        ptr <= '0;
      end
    end
  end

  // Move operands and result registers.
  always_ff @(posedge clk) begin
    rd_idx <= ptr;
    if (accept) begin
      mover     <= IDX_W'(entry_index);
      move_axis <= axis;
      dest      <= dest_pos;
    end
    if (state == ST_SETUP) begin
      size        <= m_size;
      sweep.cur   <= m_cur;
      sweep.axis  <= move_axis;
      if (move_axis == AXIS_Y) begin
        sweep.x_lo <= b_lo;
        sweep.x_hi <= b_hi;
        sweep.y_lo <= a_lo;
        sweep.y_hi <= a_hi;
      end else begin
        sweep.x_lo <= a_lo;
        sweep.x_hi <= a_hi;
        sweep.y_lo <= b_lo;
        sweep.y_hi <= b_hi;
      end
      result_pos <= m_cur;
      hit        <= 1'b0;
      hit_index  <= '0;
    end else if (state == ST_FINISH) begin
      result_pos <= res_sat;
      hit        <= best.found;
      hit_index  <= best.found ? 6'(best_idx) : 6'd0;
    end
  end

endmodule

/* verif/swept_aabb_axis_resolver_tb.sv */
module swept_aabb_axis_resolver_tb;
  import sar_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 100;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic [30:0] SIZE_MAX = 31'h7FFF_FFFF;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  // One item as presented on the command ports.
  typedef struct {
    logic               cmd;
    logic [5:0]         idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [30:0]        w;
    logic [30:0]        h;
    logic               col;
    logic               ax;
    logic signed [31:0] dest;
  } item_t;

  // Resolved position expected from one move.
  typedef struct {
    logic signed [31:0] pos;
    logic               hit;
    logic [5:0]         hit_idx;
  } move_result_t;

  // Mirror of the box table and the queue of resolved moves still due.
  class move_tracker;
    longint box_left[TABLE_DEPTH];
    longint box_top[TABLE_DEPTH];
    longint box_w[TABLE_DEPTH];
    longint box_h[TABLE_DEPTH];
    bit box_coll[TABLE_DEPTH];
    bit written[TABLE_DEPTH];
    move_result_t expected_moves[$];
    int errors;

    static function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Store a write, or resolve a move against the current table.
    function void note_item(item_t it);
      longint qx, qy, qw, qh, cur, size, res, dst, near, far, gap, best, span;
      bit found;
      int win;
      move_result_t r;
      if (it.cmd == CMD_WRITE) begin
        box_left[it.idx] = it.px;
        box_top[it.idx] = it.py;
        box_w[it.idx] = it.w;
        box_h[it.idx] = it.h;
        box_coll[it.idx] = it.col;
        written[it.idx] = 1'b1;
        return;
      end
      qx = box_left[it.idx];
      qy = box_top[it.idx];
      qw = box_w[it.idx];
      qh = box_h[it.idx];
      cur = (it.ax == AXIS_Y) ? qy : qx;
      size = (it.ax == AXIS_Y) ? qh : qw;
      dst = it.dest;
      res = cur;
      found = 1'b0;
      best = 0;
      win = 0;
      if (dst != cur) begin
        // Swept region on the move axis; the other axis keeps the box extent.
        if (it.ax == AXIS_Y) begin
          qy = (dst < cur) ? dst : cur + size;
          qh = mag(dst - cur);
        end else begin
          qx = (dst < cur) ? dst : cur + size;
          qw = mag(dst - cur);
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!box_coll[i] || i == it.idx) continue;
          if (!(qx < box_left[i] + box_w[i] && qx + qw > box_left[i] &&
                qy < box_top[i] + box_h[i] && qy + qh > box_top[i])) continue;
          near = (it.ax == AXIS_Y) ? box_top[i] : box_left[i];
          far = near + ((it.ax == AXIS_Y) ? box_h[i] : box_w[i]);
          gap = (mag(near - cur) < mag(far - cur)) ? mag(near - cur) : mag(far - cur);
          // Strict compare keeps the lowest index on a tie.
          if (!found || gap < best) begin
            found = 1'b1;
            best = gap;
            win = i;
          end
        end
        if (!found) begin
          res = dst;
        end else begin
          near = (it.ax == AXIS_Y) ? box_top[win] : box_left[win];
          span = (it.ax == AXIS_Y) ? box_h[win] : box_w[win];
          res = (cur < near) ? near - size : near + span;
        end
      end
      if (res > longint'(COORD_MAX)) res = COORD_MAX;
      if (res < longint'(COORD_MIN)) res = COORD_MIN;
      r.pos = res[31:0];
      r.hit = found;
      r.hit_idx = found ? win[5:0] : 6'd0;
      expected_moves = {expected_moves, r};
    endfunction

    // Compare one result with the oldest move still due.
    function void check_result(logic signed [31:0] pos, logic h, logic [5:0] hi);
      move_result_t e;
      if (expected_moves.size() == 0) begin
        $error("result with no move pending: result_pos %0d hit %0b hit_index %0d",
               pos, h, hi);
        errors++;
        return;
      end
      e = expected_moves.pop_front();
      if (pos !== e.pos) begin
        $error("result_pos: expected %0d, got %0d", e.pos, pos);
        errors++;
      end
      if (h !== e.hit) begin
        $error("hit: expected %0b, got %0b", e.hit, h);
        errors++;
      end
      if (hi !== e.hit_idx) begin
        $error("hit_index: expected %0d, got %0d", e.hit_idx, hi);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               cmd;
  logic [5:0]         entry_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [30:0]        width;
  logic [30:0]        height;
  logic               collidable;
  logic               axis;
  logic signed [31:0] dest_pos;
  logic               done;
  logic signed [31:0] result_pos;
  logic               hit;
  logic [5:0]         hit_index;

  move_tracker sb = new();
  int send_idle_pct;
  int cycle_count;

  swept_aabb_axis_resolver DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .entry_index (entry_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .width       (width),
    .height      (height),
    .collidable  (collidable),
    .axis        (axis),
    .dest_pos    (dest_pos),
    .done        (done),
    .result_pos  (result_pos),
    .hit         (hit),
    .hit_index   (hit_index)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Results are strobed for one cycle and taken at the closing edge.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result_pos, hit, hit_index);
  end

  // Present one item from a falling edge and hold it until accepted.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    cmd = it.cmd;
    entry_index = it.idx;
    pos_x = it.px;
    pos_y = it.py;
    width = it.w;
    height = it.h;
    collidable = it.col;
    axis = it.ax;
    dest_pos = it.dest;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    @(negedge clk);
  endtask

  // Write one box; the move fields carry junk.
  task automatic put_box(input logic [5:0] idx, input logic signed [31:0] px,
                         input logic signed [31:0] py, input logic [30:0] w,
                         input logic [30:0] h, input logic col);
    item_t it;
    it.cmd = CMD_WRITE;
    it.idx = idx;
    it.px = px;
    it.py = py;
    it.w = w;
    it.h = h;
    it.col = col;
    it.ax = 1'($urandom_range(1));
    it.dest = $urandom;
    send_item(it);
  endtask

  // Move one box along an axis; the write fields carry junk.
  task automatic put_move(input logic [5:0] idx, input logic ax,
                          input logic signed [31:0] dest);
    item_t it;
    it.cmd = CMD_MOVE;
    it.idx = idx;
    it.px = $urandom;
    it.py = $urandom;
    it.w = 31'($urandom);
    it.h = 31'($urandom);
    it.col = 1'($urandom_range(1));
    it.ax = ax;
    it.dest = dest;
    send_item(it);
  endtask

  initial begin
    logic [5:0] idx;
    logic signed [31:0] cur;
    logic pick;
    int roll;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_WRITE;
    entry_index = '0;
    pos_x = '0;
    pos_y = '0;
    width = '0;
    height = '0;
    collidable = 1'b0;
    axis = AXIS_X;
    dest_pos = '0;
    send_idle_pct = 21;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Small scene near the origin: a mover, two tied blockers, a ghost box
    // that is not collidable, and a blocker above the mover.
    put_box(6'd0, 32'sd0, 32'sd0, ONE, ONE, 1'b1);
    put_box(6'd1, 5 * ONE, 32'sd0, 2 * ONE, ONE, 1'b1);
    put_box(6'd2, 5 * ONE, 32'sd0, 2 * ONE, ONE, 1'b1);
    put_box(6'd3, 3 * ONE, 32'sd0, ONE / 2, ONE, 1'b0);
    put_box(6'd4, 32'sd0, 8 * ONE, ONE, ONE, 1'b1);
    put_move(6'd0, AXIS_X, 16 * ONE);
    put_move(6'd0, AXIS_X, 32'sd0);
    put_move(6'd0, AXIS_X, -16 * ONE);
    put_move(6'd0, AXIS_Y, 32 * ONE);
    put_move(6'd0, AXIS_Y, -4 * ONE);
    put_move(6'd1, AXIS_X, 32'sd0);
    put_move(6'd0, AXIS_X, COORD_MIN);
    // The mover keeps colliding after its own flag is cleared.
    put_box(6'd0, 32'sd0, 32'sd0, ONE, ONE, 1'b0);
    put_move(6'd0, AXIS_X, 16 * ONE);
    put_move(6'd1, AXIS_X, 32'sd0);

    // Far bands where the landing position runs past either end of range.
    put_box(6'd10, 32'sh7FFF_0000, 32'sh4000_0000, SIZE_MAX, ONE, 1'b1);
    put_box(6'd11, 32'sh7FFF_FFF0, 32'sh4000_0000, 31'h10, ONE, 1'b1);
    put_move(6'd11, AXIS_X, 32'sd0);
    put_box(6'd12, COORD_MIN + 5, 32'sh5000_0000, SIZE_MAX, ONE, 1'b1);
    put_box(6'd63, COORD_MIN, 32'sh5000_0000, SIZE_MAX, ONE, 1'b0);
    put_move(6'd63, AXIS_X, COORD_MAX);
    put_move(6'd12, AXIS_Y, COORD_MIN);
    put_move(6'd11, AXIS_Y, COORD_MAX);

    // Random scenes: mostly small boxes close together so that sweeps hit.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_idle_pct = (n < RANDOM_ITEMS / 3) ? 21 : (n < 2 * RANDOM_ITEMS / 3) ? 54 : 0;
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(9) == 0)
          put_box(6'($urandom_range(63)), $urandom, $urandom, 31'($urandom),
                  31'($urandom), 1'($urandom_range(1)));
        else
          put_box(6'($urandom_range(63)),
                  $urandom_range(0, 96 << 16) - (48 << 16),
                  $urandom_range(0, 96 << 16) - (48 << 16),
                  31'($urandom_range(0, 12 << 16)), 31'($urandom_range(0, 12 << 16)),
                  $urandom_range(3) != 0);
      end else begin
        // Only boxes that have been written may move.
        do idx = 6'($urandom_range(63)); while (!sb.written[idx]);
        pick = 1'($urandom_range(1));
        cur = (pick == AXIS_Y) ? sb.box_top[idx][31:0] : sb.box_left[idx][31:0];
        roll = $urandom_range(99);
        if (roll < 12)
          put_move(idx, pick, cur);
        else if (roll < 70)
          put_move(idx, pick, cur + $urandom_range(0, 40 << 16) - (20 << 16));
        else if (roll < 88)
          put_move(idx, pick, $urandom);
        else if (roll < 94)
          put_move(idx, pick, COORD_MAX);
        else
          put_move(idx, pick, COORD_MIN);
      end
    end
    start = 1'b0;

    // Let the last moves come back, then allow for a trailing stray result.
    while (sb.expected_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
